// ----- hw/rtl/fse_pkg.sv -----
// fse_pkg: shared constants, byte order codes and bit reordering helpers
// for the frame signal extractor. No dependencies.
package fse_pkg;

	localparam int FRAME_W   = 64;   // payload bits at the port
	localparam int BYTE_W    = 8;
	localparam int START_W   = 6;
	localparam int LEN_W     = 6;
	localparam int VALUE_W   = 32;

	localparam int FRAME_BYTES_DEF     = 8;
	localparam int MAX_SIGNAL_BITS_DEF = 32;

	// byte order codes
	localparam logic ORDER_INTEL    = 1'b0;
	localparam logic ORDER_MOTOROLA = 1'b1;

	// Mirror the bits inside every byte: bit i of a byte moves to bit 7-i.
	function automatic logic [FRAME_W-1:0] mirror_bytes(input logic [FRAME_W-1:0] d);
		logic [FRAME_W-1:0] r;
		r = '0;
		for (int i = 0; i < FRAME_W; i++) begin
			r[i ^ (BYTE_W - 1)] = d[i];
		end
		return r;
	endfunction

	// Full reversal of a value word.
	function automatic logic [VALUE_W-1:0] reverse_word(input logic [VALUE_W-1:0] d);
		logic [VALUE_W-1:0] r;
		r = '0;
		for (int i = 0; i < VALUE_W; i++) begin
			r[VALUE_W - 1 - i] = d[i];
		end
		return r;
	endfunction

	// Low-ones mask of the given length; lengths of VALUE_W or more give all ones.
	function automatic logic [VALUE_W-1:0] len_mask(input logic [LEN_W-1:0] len);
		logic [2*VALUE_W-1:0] t;
		t = ({{(2*VALUE_W-1){1'b0}}, 1'b1} << len) - 1'b1;
		return t[VALUE_W-1:0];
	endfunction

endpackage

// ----- hw/rtl/frame_signal_extract_core.sv -----
// frame_signal_extract_core: four-stage pipeline that pulls one signal out
// of an 8-byte frame payload in Intel or Motorola byte order.
// Depends on fse_pkg.

// Usage
//   Input channel (in_valid / in_stall) carries one item: the frame payload
//   plus a descriptor (sig_start, sig_len, sig_order, sig_signed).
//   Output channel (out_valid / out_stall) returns signal_value, one item
//   per input item, in order.
//   An item moves through registers s1 to s4, so four items can be in
//   flight at once; out_valid is the valid flag of s4.
//   Throughput: one item per cycle while the receiver does not stall.
//   Stages: s1 masks bytes beyond the payload and, for Motorola order,
//   mirrors each byte so the signal reads as a contiguous run; s2 is the
//   64-bit barrel shift to the first signal bit; s3 reverses Motorola
//   fields, aligns and masks to the length; s4 sign-extends and zeroes
//   invalid lengths (0 or above MAX_SIGNAL_BITS).
//   When the receiver stalls a valid output, the whole pipeline holds and
//   in_stall rises in the same cycle; nothing is dropped or repeated.
//   Reset (arst_n low) empties the pipeline; no other state exists.
module frame_signal_extract_core
	import fse_pkg::*;
#(
	parameter int FRAME_BYTES     = FRAME_BYTES_DEF,
	parameter int MAX_SIGNAL_BITS = MAX_SIGNAL_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [FRAME_W-1:0]        frame_data,
	input  logic [START_W-1:0]        sig_start,
	input  logic [LEN_W-1:0]          sig_len,
	input  logic                      sig_order,
	input  logic                      sig_signed,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [VALUE_W-1:0] signal_value
);

	localparam int SH_W = $clog2(VALUE_W);

	// payload bytes at or past FRAME_BYTES read as zero
	localparam logic [FRAME_W:0] KEEP_FULL =
		{{FRAME_W{1'b0}}, 1'b1} << (FRAME_BYTES * BYTE_W);
	localparam logic [FRAME_W-1:0] KEEP_MASK = FRAME_W'(KEEP_FULL - 1'b1);

	logic en;

	logic v_s1, v_s2, v_s3, v_s4;

	logic [FRAME_W-1:0] src_s1;
	logic [START_W-1:0] amt_s1;
	logic [LEN_W-1:0]   len_s1, len_s2, len_s3, len_s4;
	logic               moto_s1, moto_s2;
	logic               sgn_s1, sgn_s2, sgn_s3, sgn_s4;
	logic               ok_s1, ok_s2, ok_s3, ok_s4;

	logic [VALUE_W-1:0] win_s2;
	logic [VALUE_W-1:0] val_s3;
	logic [VALUE_W-1:0] val_s4;

	logic [FRAME_W-1:0] frame_kept;
	logic [FRAME_W-1:0] src_d;
	logic [START_W-1:0] amt_d;
	logic [FRAME_W-1:0] shifted;
	logic [VALUE_W-1:0] rev_win;
	logic [LEN_W-1:0]   rsh;
	logic [VALUE_W-1:0] aligned;
	logic [VALUE_W-1:0] mask_s3;
	logic [VALUE_W-1:0] mask_s4;
	logic [LEN_W-1:0]   top_idx;
	logic [VALUE_W-1:0] ext_val;

	// global hold while a finished item waits at the output
	assign en       = !(v_s4 && out_stall);
	assign in_stall = !en;

	// s1: byte masking and Motorola mirroring. Mirroring turns the
	// Motorola walk (down within a byte, then bit 7 of the next byte) into
	// an upward run starting at byte*8 + (7 - bit).
	always_comb begin
		frame_kept = frame_data & KEEP_MASK;
		if (sig_order == ORDER_MOTOROLA) begin
			src_d = mirror_bytes(frame_kept);
			amt_d = {sig_start[START_W-1:3], ~sig_start[2:0]};
		end else begin
			src_d = frame_kept;
			amt_d = sig_start;
		end
	end

	// s2: shift the first signal bit down to bit 0; bits past the top read zero
	assign shifted = src_s1 >> amt_s1;

	// s3: Motorola fields come out first-bit-low, so reverse and right-align
	always_comb begin
		rev_win = reverse_word(win_s2);
		rsh     = LEN_W'(VALUE_W) - len_s2;
		mask_s3 = len_mask(len_s2);
		if (moto_s2) begin
			aligned = (rev_win >> rsh[SH_W-1:0]) & mask_s3;
		end else begin
			aligned = win_s2 & mask_s3;
		end
	end

	// s4 input: sign extension from the field's top bit; zero for bad lengths
	always_comb begin
		mask_s4 = len_mask(len_s3);
		top_idx = len_s3 - 1'b1;
		ext_val = val_s3;
		if (sgn_s3 && val_s3[top_idx[SH_W-1:0]]) begin
			ext_val = val_s3 | ~mask_s4;
		end
		if (!ok_s3) begin
			ext_val = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			src_s1  <= src_d;
			amt_s1  <= amt_d;
			len_s1  <= sig_len;
			moto_s1 <= (sig_order == ORDER_MOTOROLA);
			sgn_s1  <= sig_signed;
			ok_s1   <= (sig_len != '0) && (sig_len <= LEN_W'(MAX_SIGNAL_BITS));

			win_s2  <= shifted[VALUE_W-1:0];
			len_s2  <= len_s1;
			moto_s2 <= moto_s1;
			sgn_s2  <= sgn_s1;
			ok_s2   <= ok_s1;

			val_s3  <= aligned;
			len_s3  <= len_s2;
			sgn_s3  <= sgn_s2;
			ok_s3   <= ok_s2;

			val_s4  <= ext_val;
			len_s4  <= len_s3;
			sgn_s4  <= sgn_s3;
			ok_s4   <= ok_s3;
		end
	end

	assign out_valid    = v_s4;
	assign signal_value = $signed(val_s4);

	// an item in s3 reaches the output on the next advancing edge
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_s3 |=> out_valid)
		else $error("item lost between s3 and output");

	// invalid lengths give zero
	a_bad_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok_s4 |-> val_s4 == '0)
		else $error("nonzero value for invalid length");

	// unsigned fields carry no bits above their length
	a_unsigned_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ok_s4 && !sgn_s4 |-> (val_s4 & ~len_mask(len_s4)) == '0)
		else $error("unsigned value has bits above its length");

	// signed fields below full width: bits above the length all 0 or all 1
	a_sign_ext: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ok_s4 && sgn_s4 && (len_s4 < LEN_W'(VALUE_W)) |->
			((val_s4 & ~len_mask(len_s4)) == '0) ||
			((val_s4 | len_mask(len_s4)) == '1))
		else $error("sign extension inconsistent");

	// the ok flag follows the length it travels with
	a_ok_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ok_s4 == ((len_s4 != '0) && (len_s4 <= LEN_W'(MAX_SIGNAL_BITS))))
		else $error("length check out of step with length");

endmodule

// ----- tb/sv/fse_value_checker.sv -----
`timescale 1ns / 100ps
// fse_value_checker: watches both channels of frame_signal_extract_core, predicts
// the signal value of every accepted item and compares it with the returned item.
// Depends on fse_pkg.
module fse_value_checker
	import fse_pkg::*;
#(
	parameter int FRAME_BYTES     = FRAME_BYTES_DEF,
	parameter int MAX_SIGNAL_BITS = MAX_SIGNAL_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic [FRAME_W-1:0]        frame_data,
	input  logic [START_W-1:0]        sig_start,
	input  logic [LEN_W-1:0]          sig_len,
	input  logic                      sig_order,
	input  logic                      sig_signed,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic signed [VALUE_W-1:0] signal_value,
	output int                        mismatch_count,
	output int                        pending_count,
	output int                        checked_count
);

	typedef struct {
		logic [VALUE_W-1:0] value;
		logic [FRAME_W-1:0] frame;
		logic [START_W-1:0] start;
		logic [LEN_W-1:0]   len;
		logic               order;
		logic               sgn;
	} signal_req_t;

	signal_req_t expected_values[$];
	int          errs    = 0;
	int          checked = 0;

	// payload bit by byte and bit index; bytes past the payload read as zero
	function automatic logic frame_bit(input logic [FRAME_W-1:0] frame, input int byte_i,
			input int bit_i);
		if (byte_i >= FRAME_BYTES || byte_i >= FRAME_W / BYTE_W)
			return 1'b0;
		return frame[byte_i * BYTE_W + bit_i];
	endfunction

	function automatic logic [VALUE_W-1:0] extract_signal(input logic [FRAME_W-1:0] frame,
			input logic [START_W-1:0] start, input logic [LEN_W-1:0] len,
			input logic order, input logic sgn);
		logic [VALUE_W-1:0] v;
		int                 byte_i;
		int                 bit_i;
		int                 pos;
		v = '0;
		if (len != 0 && len <= MAX_SIGNAL_BITS && len <= VALUE_W) begin
			if (order == ORDER_INTEL) begin
				for (int k = 0; k < len; k++) begin
					pos  = start + k;
					v[k] = frame_bit(frame, pos / BYTE_W, pos % BYTE_W);
				end
			end else begin
				// start is the MSB; walk down the byte, then on from bit 7 of the next
				byte_i = start / BYTE_W;
				bit_i  = start % BYTE_W;
				for (int k = 0; k < len; k++) begin
					v = {v[VALUE_W-2:0], frame_bit(frame, byte_i, bit_i)};
					if (bit_i == 0) begin
						byte_i++;
						bit_i = BYTE_W - 1;
					end else begin
						bit_i--;
					end
				end
			end
			if (sgn && len < VALUE_W && v[len - 1])
				v = v | ~((32'd1 << len) - 32'd1);
		end
		return v;
	endfunction

	always @(posedge clk) begin : watch
		signal_req_t req;
		signal_req_t head;
		if (!arst_n) begin
			expected_values.delete();
			mismatch_count <= 0;
			pending_count  <= 0;
			checked_count  <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_values.size() == 0) begin
					if (errs < 10)
						$display("%t: result %h with no item outstanding", $realtime,
							signal_value);
					errs++;
				end else begin
					head = expected_values.pop_front();
					checked++;
					if (signal_value !== head.value) begin
						if (errs < 10)
							$display({"%t: frame=%h start=%0d len=%0d order=%0d",
								" sgn=%0d expected %h got %h"},
								$realtime, head.frame, head.start, head.len, head.order,
								head.sgn, head.value, signal_value);
						errs++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				req.frame = frame_data;
				req.start = sig_start;
				req.len   = sig_len;
				req.order = sig_order;
				req.sgn   = sig_signed;
				req.value = extract_signal(frame_data, sig_start, sig_len, sig_order,
					sig_signed);
				expected_values.push_back(req);
			end
			mismatch_count <= errs;
			pending_count  <= expected_values.size();
			checked_count  <= checked;
		end
	end

endmodule

// ----- tb/sv/tb_frame_signal_extract_core.sv -----
`timescale 1ns / 100ps
// tb_frame_signal_extract_core: stimulus and verdict for frame_signal_extract_core.
// Uses fse_pkg and fse_value_checker, which predicts and compares every item.
module tb_frame_signal_extract_core;
	import fse_pkg::*;

	localparam int PHASE_ITEMS = 585;   // random items per idle mix, three mixes

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic [FRAME_W-1:0]        frame_data;
	logic [START_W-1:0]        sig_start;
	logic [LEN_W-1:0]          sig_len;
	logic                      sig_order;
	logic                      sig_signed;
	logic                      out_valid;
	logic                      out_stall;
	logic signed [VALUE_W-1:0] signal_value;

	int mismatch_count;
	int pending_count;
	int checked_count;
	int items_sent     = 0;
	int send_idle_pct  = 0;   // chance per cycle that the sender holds off
	int recv_stall_pct = 0;   // chance per cycle that the receiver stalls

	frame_signal_extract_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.frame_data  (frame_data),
		.sig_start   (sig_start),
		.sig_len     (sig_len),
		.sig_order   (sig_order),
		.sig_signed  (sig_signed),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.signal_value(signal_value)
	);

	fse_value_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.frame_data    (frame_data),
		.sig_start     (sig_start),
		.sig_len       (sig_len),
		.sig_order     (sig_order),
		.sig_signed    (sig_signed),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.signal_value  (signal_value),
		.mismatch_count(mismatch_count),
		.pending_count (pending_count),
		.checked_count (checked_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: stall drawn fresh every cycle, independent of out_valid
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// run limit, far above the slowest legal run
	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// Present one item and hold it until the edge that accepts it. Valid stays
	// high into the next item unless the sender decides to idle.
	task automatic send_item(input logic [FRAME_W-1:0] f, input logic [START_W-1:0] s,
			input logic [LEN_W-1:0] l, input logic o, input logic g);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		frame_data <= f;
		sig_start  <= s;
		sig_len    <= l;
		sig_order  <= o;
		sig_signed <= g;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
	endtask

	// Mostly well-formed descriptors; some zero and oversize lengths.
	task automatic random_item();
		logic [FRAME_W-1:0] f;
		logic [LEN_W-1:0]   l;
		int                 kind;
		case ($urandom_range(9))
			0: f = '0;
			1: f = '1;
			default: f = {$urandom(), $urandom()};
		endcase
		kind = $urandom_range(99);
		if (kind < 85)
			l = LEN_W'($urandom_range(MAX_SIGNAL_BITS_DEF, 1));
		else if (kind < 92)
			l = '0;
		else
			l = LEN_W'($urandom_range(63, MAX_SIGNAL_BITS_DEF + 1));
		send_item(f, START_W'($urandom_range(63)), l, 1'($urandom_range(1)),
			1'($urandom_range(1)));
	endtask

	// hold off the sender until every outstanding item has come back
	task automatic drain_pipe();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		frame_data <= '0;
		sig_start  <= '0;
		sig_len    <= '0;
		sig_order  <= ORDER_INTEL;
		sig_signed <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, both orders, length limits, payload edge
		send_item('0, 6'd0, 6'd1, ORDER_INTEL, 1'b0);
		send_item('1, 6'd0, 6'd32, ORDER_INTEL, 1'b0);
		send_item('1, 6'd0, 6'd32, ORDER_INTEL, 1'b1);     // full width, no extension
		send_item('1, 6'd0, 6'd0, ORDER_INTEL, 1'b1);      // zero length
		send_item('1, 6'd5, 6'd33, ORDER_INTEL, 1'b0);     // just over the limit
		send_item('1, 6'd63, 6'd63, ORDER_MOTOROLA, 1'b1); // largest length
		send_item(64'h0123_4567_89AB_CDEF, 6'd63, 6'd1, ORDER_INTEL, 1'b0);
		send_item(64'h0123_4567_89AB_CDEF, 6'd56, 6'd8, ORDER_INTEL, 1'b1);
		send_item('1, 6'd60, 6'd16, ORDER_INTEL, 1'b0);    // runs off the top byte
		send_item('1, 6'd60, 6'd16, ORDER_INTEL, 1'b1);
		send_item(64'h0123_4567_89AB_CDEF, 6'd7, 6'd8, ORDER_MOTOROLA, 1'b0);
		send_item(64'h0123_4567_89AB_CDEF, 6'd3, 6'd12, ORDER_MOTOROLA, 1'b1);
		send_item(64'h0123_4567_89AB_CDEF, 6'd0, 6'd32, ORDER_MOTOROLA, 1'b1);
		send_item('1, 6'd63, 6'd32, ORDER_MOTOROLA, 1'b0); // Motorola past payload
		send_item('1, 6'd57, 6'd20, ORDER_MOTOROLA, 1'b1);
		send_item(64'h8000_0000_0000_0000, 6'd63, 6'd1, ORDER_INTEL, 1'b1);
		send_item(64'h8000_0000_0000_0000, 6'd63, 6'd1, ORDER_MOTOROLA, 1'b1);
		send_item(64'hAAAA_5555_AAAA_5555, 6'd31, 6'd31, ORDER_MOTOROLA, 1'b1);
		send_item(64'hAAAA_5555_AAAA_5555, 6'd1, 6'd31, ORDER_INTEL, 1'b1);
		send_item(64'hFFFF_FFFF_0000_0000, 6'd32, 6'd32, ORDER_INTEL, 1'b1);

		// sender idles often, receiver stalls heavily
		send_idle_pct  = 36;
		recv_stall_pct = 85;
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			if (i == PHASE_ITEMS / 2)
				drain_pipe();
			random_item();
		end

		// the other way round
		send_idle_pct  = 85;
		recv_stall_pct = 36;
		for (int i = 0; i < PHASE_ITEMS; i++)
			random_item();

		// back to back on both sides
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		for (int i = 0; i < PHASE_ITEMS; i++)
			random_item();

		drain_pipe();
		repeat (8) @(posedge clk);

		$display("%0d items sent: directed corners, then random descriptors under three idle mixes",
			items_sent);
		$display("%0d results compared, %0d mismatches", checked_count, mismatch_count);
		if (mismatch_count == 0 && pending_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
